>>> design/otb_pkg.sv
// Shared types, constants and helper functions for the ordered software timer bank.
// Used by otb_cell, ordered_software_timer_bank and otb_checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package otb_pkg;

    // Bank size and derived widths
    localparam int TIMER_SLOTS  = 16;
    localparam int HANDLE_W     = 4;
    localparam int HANDLE_SPACE = 1 << HANDLE_W;
    localparam int HANDLE_LIMIT = (TIMER_SLOTS < HANDLE_SPACE) ? TIMER_SLOTS : HANDLE_SPACE;
    localparam int COUNT_W      = $clog2(TIMER_SLOTS + 1);

    // Field widths
    localparam int CMD_W      = 2;
    localparam int INTERVAL_W = 32;
    localparam int TIME_W     = 48;
    localparam int STATUS_W   = 3;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;

    // Input tdata layout, lowest bit first
    localparam int IN_CMD_LSB      = 0;
    localparam int IN_HANDLE_LSB   = IN_CMD_LSB + CMD_W;
    localparam int IN_INTERVAL_LSB = IN_HANDLE_LSB + HANDLE_W;
    localparam int IN_ONE_SHOT_LSB = IN_INTERVAL_LSB + INTERVAL_W;
    localparam int IN_NOW_LSB      = IN_ONE_SHOT_LSB + 1;
    localparam int IN_BITS         = IN_NOW_LSB + TIME_W;
    localparam int IN_TDATA_W      = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bit first
    localparam int OUT_STATUS_LSB = 0;
    localparam int OUT_FIRED_LSB  = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_HANDLE_LSB = OUT_FIRED_LSB + 1;
    localparam int OUT_BITS       = OUT_HANDLE_LSB + HANDLE_W;
    localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] MIN_INTERVAL_RESET = CFG_W'(50);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALTED       = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SCAN   = 2'd2
    } otb_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE    = 3'd0,
        STATUS_FULL    = 3'd1,
        STATUS_HALTED  = 3'd2,
        STATUS_NONE    = 3'd3,
        STATUS_UNKNOWN = 3'd4
    } otb_status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EVAL,
        FSM_APPLY
    } otb_fsm_t;

    // Contents of one timer cell
    typedef struct packed {
        logic [HANDLE_W-1:0]   handle;
        logic                  armed;
        logic                  one_shot;
        logic [INTERVAL_W-1:0] interval;
        logic [TIME_W-1:0]     deadline;
    } otb_entry_t;

    // Commands from the sequencer to one cell
    typedef struct packed {
        logic eval;
        logic load;
        logic shift;
        logic fire;
    } otb_cell_ctrl_t;

    // Registered findings of one cell
    typedef struct packed {
        logic hit;
        logic match;
    } otb_cell_stat_t;

    // Deadline now plus interval, saturated at the top of the time range.
    function automatic logic [TIME_W-1:0] sat_deadline(input logic [TIME_W-1:0] now,
                                                       input logic [INTERVAL_W-1:0] iv);
        logic [TIME_W:0] sum;
        sum = {1'b0, now} + {{(TIME_W + 1 - INTERVAL_W){1'b0}}, iv};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/otb_cell.sv
// One timer cell of the bank: holds an entry, evaluates it and shifts from its neighbour.
// Depends on otb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module otb_cell (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire otb_pkg::otb_cell_ctrl_t        ctrl,
    input  wire logic [otb_pkg::TIME_W-1:0]     now_ms,
    input  wire logic [otb_pkg::HANDLE_W-1:0]   del_handle,
    input  wire otb_pkg::otb_entry_t            new_entry,
    input  wire logic                           nb_valid,
    input  wire otb_pkg::otb_entry_t            nb_entry,
    output logic                                valid,
    output otb_pkg::otb_entry_t                 entry,
    output otb_pkg::otb_cell_stat_t             stat
);

    logic                           valid_reg;
    otb_pkg::otb_entry_t            entry_reg;
    otb_pkg::otb_cell_stat_t        stat_reg;
    logic [otb_pkg::TIME_W-1:0]     renew_reg;

    // Occupancy and evaluation flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            stat_reg  <= '0;
        end else begin
            if (ctrl.shift) begin
                valid_reg <= nb_valid;
            end else if (ctrl.load) begin
                valid_reg <= 1'b1;
            end
            if (ctrl.eval) begin
                stat_reg.hit   <= valid_reg && entry_reg.armed && (now_ms >= entry_reg.deadline);
                stat_reg.match <= valid_reg && (entry_reg.handle == del_handle);
            end
        end
    end

    // Entry contents: shift from the neighbour, load a new entry, or fire
    always_ff @(posedge aclk) begin
        if (ctrl.eval) begin
            renew_reg <= otb_pkg::sat_deadline(now_ms, entry_reg.interval);
        end
        priority if (ctrl.shift) begin
            entry_reg <= nb_entry;
        end else if (ctrl.load) begin
            entry_reg <= new_entry;
        end else if (ctrl.fire) begin
            if (entry_reg.one_shot) begin
                entry_reg.armed <= 1'b0;
            end else begin
                entry_reg.deadline <= renew_reg;
            end
        end
    end

    assign valid = valid_reg;
    assign entry = entry_reg;
    assign stat  = stat_reg;

endmodule

`default_nettype wire

>>> design/ordered_software_timer_bank.sv
// Top level of the ordered software timer bank: item register, sequencer and cell chain.
// Depends on otb_pkg and otb_cell.
`timescale 1ns / 1ps
`default_nettype none

// The bank keeps up to TIMER_SLOTS timers in insertion order in a row of cells, one entry
// per cell. Each item (add, delete or scan) gives exactly one result item. From its
// acceptance an item passes through an evaluation step, in which every cell compares its
// deadline and handle in parallel and registers the outcome, and then an update step, in
// which the first hit or match is picked and the cells are updated (a delete shifts every
// later cell down from its neighbour). The bank accepts a new item only after the last
// one has finished its update step; a result waiting at the output does not stop the
// next item from being accepted, but its update step waits until the output is free.
// Reset clears the cells' valid flags at once, so no clearing pass is needed.
module ordered_software_timer_bank (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [otb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [otb_pkg::CFG_W-1:0]           cfg_wdata,
    // Command items
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // s_tdata: command[1:0], timer_handle[5:2], interval_ms[37:6], one_shot[38],
    //          now_ms[86:39], zero fill above
    input  wire logic [otb_pkg::IN_TDATA_W-1:0]      s_tdata,
    // Result items
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // m_tdata: status[2:0], fired[3], result_handle[7:4]
    output logic [otb_pkg::OUT_TDATA_W-1:0]          m_tdata
);

    localparam int SLOTS = otb_pkg::TIMER_SLOTS;
    localparam int HL    = otb_pkg::HANDLE_LIMIT;
    localparam int HW    = otb_pkg::HANDLE_W;

    // Configuration registers
    logic                          halted_reg;
    logic [otb_pkg::CFG_W-1:0]     min_interval_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halted_reg       <= 1'b0;
            min_interval_reg <= otb_pkg::MIN_INTERVAL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                otb_pkg::REG_HALTED:       halted_reg       <= cfg_wdata[0];
                otb_pkg::REG_MIN_INTERVAL: min_interval_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer
    otb_pkg::otb_fsm_t state_reg, state_next;
    logic              accept;
    logic              eval_en;
    logic              apply_en;
    logic              m_tvalid_reg;

    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            otb_pkg::FSM_IDLE:  if (accept) state_next = otb_pkg::FSM_EVAL;
            otb_pkg::FSM_EVAL:  state_next = otb_pkg::FSM_APPLY;
            otb_pkg::FSM_APPLY: if (apply_en) state_next = otb_pkg::FSM_IDLE;
            default:            state_next = otb_pkg::FSM_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == otb_pkg::FSM_IDLE);
        eval_en  = (state_reg == otb_pkg::FSM_EVAL);
        apply_en = (state_reg == otb_pkg::FSM_APPLY) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= otb_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Captured item
    logic [otb_pkg::CMD_W-1:0]      cmd_reg;
    logic [HW-1:0]                  handle_reg;
    logic [otb_pkg::INTERVAL_W-1:0] interval_reg;
    logic                           one_shot_reg;
    logic [otb_pkg::TIME_W-1:0]     now_reg;
    logic [otb_pkg::INTERVAL_W-1:0] add_interval_reg;
    logic [otb_pkg::TIME_W-1:0]     add_deadline_reg;
    logic [otb_pkg::INTERVAL_W-1:0] add_interval;
    logic [otb_pkg::INTERVAL_W-1:0] min_wide;

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= s_tdata[otb_pkg::IN_CMD_LSB +: otb_pkg::CMD_W];
            handle_reg   <= s_tdata[otb_pkg::IN_HANDLE_LSB +: HW];
            interval_reg <= s_tdata[otb_pkg::IN_INTERVAL_LSB +: otb_pkg::INTERVAL_W];
            one_shot_reg <= s_tdata[otb_pkg::IN_ONE_SHOT_LSB];
            now_reg      <= s_tdata[otb_pkg::IN_NOW_LSB +: otb_pkg::TIME_W];
        end
        if (eval_en) begin
            add_interval_reg <= add_interval;
            add_deadline_reg <= otb_pkg::sat_deadline(now_reg, add_interval);
        end
    end

    // Requested interval raised to the minimum
    assign min_wide     = {{(otb_pkg::INTERVAL_W - otb_pkg::CFG_W){1'b0}}, min_interval_reg};
    assign add_interval = (interval_reg < min_wide) ? min_wide : interval_reg;

    // Cell chain; the position past the last cell reads as empty
    otb_pkg::otb_cell_ctrl_t  cell_ctrl [SLOTS];
    otb_pkg::otb_cell_stat_t  cell_stat [SLOTS];
    otb_pkg::otb_entry_t      chain_entry [SLOTS+1];
    logic [SLOTS:0]           chain_valid;
    otb_pkg::otb_entry_t      new_entry;
    logic [SLOTS-1:0]         load_vec;
    logic [SLOTS-1:0]         shift_vec;
    logic [SLOTS-1:0]         fire_vec;

    assign chain_entry[SLOTS] = '0;
    assign chain_valid[SLOTS] = 1'b0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        assign cell_ctrl[i] = '{eval: eval_en, load: load_vec[i],
                                shift: shift_vec[i], fire: fire_vec[i]};
        otb_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl[i]),
            .now_ms     (now_reg),
            .del_handle (handle_reg),
            .new_entry  (new_entry),
            .nb_valid   (chain_valid[i+1]),
            .nb_entry   (chain_entry[i+1]),
            .valid      (chain_valid[i]),
            .entry      (chain_entry[i]),
            .stat       (cell_stat[i])
        );
    end

    // Bookkeeping registers
    logic [HL-1:0]              busy_reg, busy_next;
    logic [otb_pkg::COUNT_W-1:0] count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= '0;
            count_reg <= '0;
        end else if (apply_en) begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    // Picks: first hit and its handle, lowest free handle
    logic [SLOTS-1:0] hit_vec, match_vec, hit_first;
    logic [HL-1:0]    free_vec, free_first;
    logic [HW-1:0]    free_idx;
    logic [HW-1:0]    hit_handle;
    logic             add_ok;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            hit_vec[i]   = cell_stat[i].hit;
            match_vec[i] = cell_stat[i].match;
        end
        hit_first  = hit_vec & (~hit_vec + SLOTS'(1));
        free_vec   = ~busy_reg;
        free_first = free_vec & (~free_vec + HL'(1));
        free_idx   = '0;
        for (int h = 0; h < HL; h++) begin
            if (free_first[h]) free_idx = free_idx | HW'(h);
        end
        hit_handle = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit_first[i]) hit_handle = hit_handle | chain_entry[i].handle;
        end
        add_ok = (free_vec != '0) && (count_reg < otb_pkg::COUNT_W'(SLOTS));
    end

    assign new_entry = '{handle: free_idx, armed: 1'b1, one_shot: one_shot_reg,
                         interval: add_interval_reg, deadline: add_deadline_reg};

    // Update step: cell commands, bookkeeping and the result
    otb_pkg::otb_status_t res_status;
    logic                 res_fired;
    logic [HW-1:0]        res_handle;
    logic                 del_ok;

    always_comb begin
        load_vec   = '0;
        shift_vec  = '0;
        fire_vec   = '0;
        busy_next  = busy_reg;
        count_next = count_reg;
        res_status = otb_pkg::STATUS_NONE;
        res_fired  = 1'b0;
        res_handle = '0;
        del_ok     = 1'b0;
        unique case (cmd_reg)
            otb_pkg::CMD_ADD: begin
                if (add_ok) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        load_vec[i] = apply_en && (count_reg == otb_pkg::COUNT_W'(i));
                    end
                    busy_next  = busy_reg | (HL'(1) << free_idx);
                    count_next = count_reg + otb_pkg::COUNT_W'(1);
                    res_status = otb_pkg::STATUS_DONE;
                    res_handle = free_idx;
                end else begin
                    res_status = otb_pkg::STATUS_FULL;
                end
            end
            otb_pkg::CMD_DELETE: begin
                del_ok = (match_vec != '0);
                if (del_ok) begin
                    // Every cell from the matching one upwards takes its neighbour's entry
                    for (int i = 0; i < SLOTS; i++) begin
                        shift_vec[i] = apply_en &&
                            ((match_vec & ({SLOTS{1'b1}} >> (SLOTS - 1 - i))) != '0);
                    end
                    busy_next  = busy_reg & ~(HL'(1) << handle_reg);
                    count_next = count_reg - otb_pkg::COUNT_W'(1);
                    res_status = otb_pkg::STATUS_DONE;
                    res_handle = handle_reg;
                end else begin
                    res_status = otb_pkg::STATUS_UNKNOWN;
                end
            end
            otb_pkg::CMD_SCAN: begin
                if (halted_reg) begin
                    res_status = otb_pkg::STATUS_HALTED;
                end else if (hit_vec != '0) begin
                    fire_vec   = apply_en ? hit_first : '0;
                    res_status = otb_pkg::STATUS_DONE;
                    res_fired  = 1'b1;
                    res_handle = hit_handle;
                end else begin
                    res_status = otb_pkg::STATUS_NONE;
                end
            end
            default: res_status = otb_pkg::STATUS_NONE;
        endcase
    end

    // Output register
    logic [otb_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (apply_en) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_en) begin
            m_tdata_reg <= otb_pkg::OUT_TDATA_W'({res_handle, res_fired, res_status});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> design/otb_checker.sv
// Port-level checks for the ordered software timer bank, bound to its top level.
// Depends on otb_pkg and ordered_software_timer_bank.
`timescale 1ns / 1ps
`default_nettype none

module otb_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [otb_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    // Reset leaves no result item pending.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result item pending after reset");

    // A stalled result item holds its contents.
    a_hold: assert property (@(posedge aclk)
        aresetn && m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    // Only a completed scan reports a fired timer.
    a_fired_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[otb_pkg::OUT_FIRED_LSB] |->
            m_tdata[otb_pkg::OUT_STATUS_LSB +: otb_pkg::STATUS_W] == otb_pkg::STATUS_DONE)
        else $error("fired flag without done status");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            m_tdata[otb_pkg::OUT_STATUS_LSB +: otb_pkg::STATUS_W] <= otb_pkg::STATUS_UNKNOWN)
        else $error("status code out of range");

    // The bank works on one item at a time.
    a_one_item: assert property (@(posedge aclk)
        aresetn && s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in progress");

endmodule

bind ordered_software_timer_bank otb_checker u_otb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/tb_ordered_software_timer_bank.sv
// Self-checking testbench for ordered_software_timer_bank: directed corner cases, then
// random add, delete and scan traffic under several register settings and idling patterns.
// Depends on otb_pkg and the design sources; the expected results come from a bench-side bank.
`timescale 1ns / 1ps

module tb_ordered_software_timer_bank;
    import otb_pkg::*;

    // The command field is two bits wide; its fourth code is not a defined command.
    localparam logic [CMD_W-1:0]  CMD_RESERVED   = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX       = {TIME_W{1'b1}};
    localparam int                LATENCY_CYCLES = 4;
    localparam int                STALL_LIMIT    = 3000;

    typedef struct {
        logic [CMD_W-1:0]      cmd;
        logic [HANDLE_W-1:0]   handle;
        logic [INTERVAL_W-1:0] interval;
        logic                  one_shot;
        logic [TIME_W-1:0]     now;
    } timer_cmd_t;

    typedef struct {
        otb_status_t         status;
        logic                fired;
        logic [HANDLE_W-1:0] handle;
    } timer_result_t;

    // Block ports, the inputs driven to known values from time zero
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Bench-side copy of the timer bank, in insertion order
    logic [HANDLE_W-1:0]     bank_handle [TIMER_SLOTS];
    logic                    bank_armed  [TIMER_SLOTS];
    logic                    bank_once   [TIMER_SLOTS];
    logic [INTERVAL_W-1:0]   bank_period [TIMER_SLOTS];
    logic [TIME_W-1:0]       bank_due    [TIMER_SLOTS];
    logic [HANDLE_SPACE-1:0] handles_in_use;
    int                      bank_count;
    logic                    cfg_halted;
    logic [CFG_W-1:0]        cfg_min_iv;

    timer_result_t    pending_results [$];
    logic [TIME_W-1:0] sim_ms;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               fail_count = 0;

    ordered_software_timer_bank DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Deadline a given interval after now, held at the top of the time range.
    function automatic logic [TIME_W-1:0] due_after(input logic [TIME_W-1:0] now,
                                                   input logic [INTERVAL_W-1:0] iv);
        logic [TIME_W:0] total;
        total = {1'b0, now} + {{(TIME_W + 1 - INTERVAL_W){1'b0}}, iv};
        return total[TIME_W] ? TIME_MAX : total[TIME_W-1:0];
    endfunction

    // Applies one command to the bench-side bank and returns the result it should give.
    function automatic timer_result_t timer_bank_outcome(input timer_cmd_t c);
        timer_result_t         r;
        int                    free_h;
        int                    hit;
        int                    k;
        logic [INTERVAL_W-1:0] iv;
        r.status = STATUS_NONE;
        r.fired  = 1'b0;
        r.handle = '0;
        case (c.cmd)
            CMD_ADD: begin
                free_h = -1;
                for (k = HANDLE_LIMIT - 1; k >= 0; k--)
                    if (!handles_in_use[k]) free_h = k;
                if (free_h < 0 || bank_count >= TIMER_SLOTS) begin
                    r.status = STATUS_FULL;
                end else begin
                    iv = (c.interval < cfg_min_iv) ? INTERVAL_W'(cfg_min_iv) : c.interval;
                    bank_handle[bank_count] = HANDLE_W'(free_h);
                    bank_armed[bank_count]  = 1'b1;
                    bank_once[bank_count]   = c.one_shot;
                    bank_period[bank_count] = iv;
                    bank_due[bank_count]    = due_after(c.now, iv);
                    handles_in_use[free_h]  = 1'b1;
                    bank_count++;
                    r.status = STATUS_DONE;
                    r.handle = HANDLE_W'(free_h);
                end
            end
            CMD_DELETE: begin
                hit = -1;
                for (k = bank_count - 1; k >= 0; k--)
                    if (bank_handle[k] == c.handle) hit = k;
                if (hit < 0) begin
                    r.status = STATUS_UNKNOWN;
                end else begin
                    // Later entries move down one place so the order stays gap-free.
                    for (k = hit; k + 1 < bank_count; k++) begin
                        bank_handle[k] = bank_handle[k + 1];
                        bank_armed[k]  = bank_armed[k + 1];
                        bank_once[k]   = bank_once[k + 1];
                        bank_period[k] = bank_period[k + 1];
                        bank_due[k]    = bank_due[k + 1];
                    end
                    bank_count--;
                    handles_in_use[c.handle] = 1'b0;
                    r.status = STATUS_DONE;
                    r.handle = c.handle;
                end
            end
            CMD_SCAN: begin
                if (cfg_halted) begin
                    r.status = STATUS_HALTED;
                end else begin
                    hit = -1;
                    for (k = bank_count - 1; k >= 0; k--)
                        if (bank_armed[k] && c.now >= bank_due[k]) hit = k;
                    if (hit >= 0) begin
                        if (bank_once[hit])
                            bank_armed[hit] = 1'b0;
                        else
                            bank_due[hit] = due_after(c.now, bank_period[hit]);
                        r.status = STATUS_DONE;
                        r.fired  = 1'b1;
                        r.handle = bank_handle[hit];
                    end
                end
            end
            default: begin
                // Undefined command: no change, nothing expired.
            end
        endcase
        return r;
    endfunction

    // Offers one command item, waits for it to be taken and records its expected result.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] h,
                             input logic [INTERVAL_W-1:0] iv, input logic once,
                             input logic [TIME_W-1:0] now);
        timer_cmd_t            c;
        logic [IN_TDATA_W-1:0] word;
        c.cmd      = cmd;
        c.handle   = h;
        c.interval = iv;
        c.one_shot = once;
        c.now      = now;
        word = '0;
        word[IN_CMD_LSB      +: CMD_W]      = cmd;
        word[IN_HANDLE_LSB   +: HANDLE_W]   = h;
        word[IN_INTERVAL_LSB +: INTERVAL_W] = iv;
        word[IN_ONE_SHOT_LSB]               = once;
        word[IN_NOW_LSB      +: TIME_W]     = now;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(timer_bank_outcome(c));
    endtask

    // Stops sending and lets every outstanding result drain.
    task automatic wait_bank_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY_CYCLES) @(posedge aclk);
    endtask

    // Writes both registers while the bank is idle.
    task automatic write_config(input logic halt, input logic [CFG_W-1:0] min_iv);
        wait_bank_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_HALTED;
        cfg_wdata <= CFG_W'(halt);
        @(posedge aclk);
        cfg_index <= REG_MIN_INTERVAL;
        cfg_wdata <= min_iv;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        cfg_halted = halt;
        cfg_min_iv = min_iv;
    endtask

    // Random traffic: a mostly advancing clock, adds, deletes of live handles and scans,
    // with some jumps in time, deletes of arbitrary handles and undefined commands.
    task automatic run_timer_traffic(input int items);
        logic [CMD_W-1:0]      cmd;
        logic [HANDLE_W-1:0]   h;
        logic [INTERVAL_W-1:0] iv;
        int                    pick;
        int                    n;
        int                    k;
        int                    live [$];
        for (n = 0; n < items; n++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                sim_ms = sim_ms + $urandom_range(40);
            else if (pick < 92)
                sim_ms = sim_ms + $urandom_range(int'(cfg_min_iv) + 300);
            else if (pick < 96)
                sim_ms = TIME_W'({$urandom, $urandom});
            else
                sim_ms = TIME_MAX - $urandom_range(2000);

            pick = $urandom_range(99);
            if (pick < 32)
                cmd = CMD_ADD;
            else if (pick < 56)
                cmd = CMD_DELETE;
            else if (pick < 96)
                cmd = CMD_SCAN;
            else
                cmd = CMD_RESERVED;

            pick = $urandom_range(99);
            if (pick < 60)
                iv = $urandom_range(2 * int'(cfg_min_iv) + 100);
            else if (pick < 80)
                iv = $urandom_range(40);
            else if (pick < 95)
                iv = $urandom;
            else
                iv = '1;

            // Deletes mostly aim at a handle that is in use.
            h = HANDLE_W'($urandom_range(HANDLE_SPACE - 1));
            live.delete();
            for (k = 0; k < HANDLE_SPACE; k++)
                if (handles_in_use[k]) live.push_back(k);
            if (cmd == CMD_DELETE && live.size() != 0 && $urandom_range(99) < 85)
                h = HANDLE_W'(live[$urandom_range(live.size() - 1)]);

            send_item(cmd, h, iv, $urandom_range(99) < 40, sim_ms);
        end
    endtask

    // Empty bank, clamping, one-shot and periodic firing, saturation, full table,
    // delete from the middle, the undefined command and a halted bank.
    task automatic test_directed_corners();
        int k;
        send_item(CMD_SCAN, 4'd0, '0, 1'b0, 48'd0);
        send_item(CMD_DELETE, 4'd15, '0, 1'b0, 48'd0);
        send_item(CMD_ADD, 4'd0, 32'd0, 1'b1, 48'd1000);
        send_item(CMD_ADD, 4'd0, '1, 1'b0, 48'd1000);
        send_item(CMD_ADD, 4'd0, 32'd10, 1'b0, 48'd1000);
        send_item(CMD_SCAN, 4'd0, '0, 1'b0, 48'd1049);
        send_item(CMD_SCAN, 4'd0, '0, 1'b0, 48'd1050);
        send_item(CMD_SCAN, 4'd0, '0, 1'b0, 48'd1050);
        send_item(CMD_SCAN, 4'd0, '0, 1'b0, 48'd1060);
        send_item(CMD_DELETE, 4'd0, '0, 1'b0, 48'd1060);
        // Deadline beyond the time range is held at its top.
        send_item(CMD_ADD, 4'd0, '1, 1'b1, TIME_MAX - 5);
        repeat (3) send_item(CMD_SCAN, 4'd0, '0, 1'b0, TIME_MAX);
        send_item(CMD_RESERVED, '1, '1, 1'b1, TIME_MAX);
        // Fill every handle, then one add too many.
        for (k = 0; k < 14; k++)
            send_item(CMD_ADD, 4'd0, 32'(k * 7), 1'(k % 2), 48'd2000);
        send_item(CMD_DELETE, 4'd7, '0, 1'b0, 48'd2000);
        write_config(1'b1, MIN_INTERVAL_RESET);
        send_item(CMD_SCAN, 4'd0, '0, 1'b0, TIME_MAX);
        send_item(CMD_ADD, 4'd0, 32'd5, 1'b0, 48'd2000);
        write_config(1'b0, MIN_INTERVAL_RESET);
        send_item(CMD_SCAN, 4'd0, '0, 1'b0, 48'd2100);
    endtask

    task automatic test_zero_min_interval();
        write_config(1'b0, 16'd0);
        run_timer_traffic(400);
    endtask

    task automatic test_largest_min_interval();
        write_config(1'b0, 16'hFFFF);
        run_timer_traffic(300);
    endtask

    task automatic test_halted_bank();
        write_config(1'b1, CFG_W'($urandom));
        run_timer_traffic(150);
    endtask

    task automatic test_random_min_interval();
        write_config(1'b0, CFG_W'($urandom_range(200)));
        run_timer_traffic(400);
    endtask

    task automatic test_back_to_back();
        write_config(1'b0, MIN_INTERVAL_RESET);
        run_timer_traffic(700);
    endtask

    // Result side back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Each result item against the oldest expectation.
    always @(posedge aclk) begin : result_check
        timer_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing outstanding: m_tdata %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[OUT_STATUS_LSB +: STATUS_W] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status,
                           m_tdata[OUT_STATUS_LSB +: STATUS_W]);
                    fail_count++;
                end
                if (m_tdata[OUT_FIRED_LSB] !== want.fired) begin
                    $error("fired: expected %0d, got %0d", want.fired,
                           m_tdata[OUT_FIRED_LSB]);
                    fail_count++;
                end
                if (m_tdata[OUT_HANDLE_LSB +: HANDLE_W] !== want.handle) begin
                    $error("result_handle: expected %0d, got %0d", want.handle,
                           m_tdata[OUT_HANDLE_LSB +: HANDLE_W]);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if neither side moves an item for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        handles_in_use = '0;
        bank_count     = 0;
        cfg_halted     = 1'b0;
        cfg_min_iv     = MIN_INTERVAL_RESET;
        sim_ms         = '0;
        send_idle_pct  = 19;
        recv_idle_pct  = 54;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_zero_min_interval();
        test_largest_min_interval();
        send_idle_pct = 54;
        recv_idle_pct = 19;
        test_halted_bank();
        test_random_min_interval();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_back_to_back();

        wait_bank_idle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
